// ===== hw/rtl/rab_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the RGB565 rotated alpha-blend pixel writer.
// No dependencies; every other file of the block imports this package.
package rab_pkg;

   localparam int unsigned DIM_W        = 11;   // panel dimension registers
   localparam int unsigned COORD_W      = 16;   // logical pixel coordinates
   localparam int unsigned COLOR_W      = 16;   // RGB565 word
   localparam int unsigned ALPHA_W      = 8;
   localparam int unsigned ADDR_OUT_W   = 17;   // reported framebuffer address
   localparam int unsigned PROD_W       = 2 * DIM_W;   // row * width + column
   localparam int unsigned CALC_W       = COORD_W + 2; // signed rotation math
   localparam int unsigned MAX_RES      = 1024;
   localparam int unsigned BOX_W        = $clog2(MAX_RES);
   localparam int unsigned CSR_IDX_W    = 2;
   localparam int unsigned CSR_DATA_W   = DIM_W;
   localparam int unsigned FB_DEPTH_DEF = 131072;

   localparam logic [DIM_W-1:0]   PANEL_WIDTH_RST  = DIM_W'(320);
   localparam logic [DIM_W-1:0]   PANEL_HEIGHT_RST = DIM_W'(240);
   localparam logic [ALPHA_W-1:0] ALPHA_SKIP       = 8'd0;
   localparam logic [ALPHA_W-1:0] ALPHA_OPAQUE     = 8'd255;
   localparam logic [15:0]        BLEND_ROUND      = 16'd128;

   localparam logic [CSR_IDX_W-1:0] CSR_ROTATION     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PANEL_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PANEL_HEIGHT = 2'd2;

   typedef enum logic [1:0] {
      ROT_0   = 2'd0,
      ROT_90  = 2'd1,
      ROT_180 = 2'd2,
      ROT_270 = 2'd3
   } rot_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_WRITE
   } rmw_state_type;

   typedef struct packed {
      rot_type          rotation;
      logic [DIM_W-1:0] panel_width;   // already saturated to MAX_RES
      logic [DIM_W-1:0] panel_height;
   } cfg_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] pixel_x;
      logic signed [COORD_W-1:0] pixel_y;
      logic [COLOR_W-1:0]        color;
      logic [ALPHA_W-1:0]        alpha_value;
      logic                      use_alpha;
      logic                      last_pixel;
   } req_payload_type;

   typedef struct packed {
      logic                  written;
      logic [ADDR_OUT_W-1:0] fb_address;
      logic [COLOR_W-1:0]    written_color;
      logic                  box_valid;
      logic [DIM_W-1:0]      box_left;
      logic [DIM_W-1:0]      box_top;
      logic [DIM_W-1:0]      box_right_end;
      logic [DIM_W-1:0]      box_bottom_end;
   } rsp_payload_type;

   // Pixel after mapping, handed from the address pipeline to the RMW engine
   typedef struct packed {
      logic               keep;
      logic               blend;
      logic               last_pixel;
      logic [DIM_W-1:0]   col;
      logic [DIM_W-1:0]   row;
      logic [COLOR_W-1:0] color;
      logic [ALPHA_W-1:0] alpha_value;
      logic [PROD_W-1:0]  addr;
   } pix_type;

endpackage

// ===== hw/rtl/rab_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for pixel requests and write reports.
// Depends on rab_pkg for the payload structs.
interface rab_req_if;
   import rab_pkg::*;
   logic            valid;
   logic            ready;
   req_payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface rab_rsp_if;
   import rab_pkg::*;
   logic            valid;
   logic            ready;
   rsp_payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/rgb565_alpha_blend_rotated_writer.sv =====
`timescale 1ns / 1ps
// Top level of the RGB565 rotated alpha-blend pixel writer: CSRs and wiring.
// Depends on rab_pkg, rab_if, rab_map, rab_rmw and rab_fb_ram.
//
//   channel   dir  handshake            carries
//   req_chan  in   valid/ready          logical pixel, color, alpha, last flag
//   rsp_chan  out  valid/ready          write report and dirty box, one per pixel
//   csr_*     in   csr_we, no wait      rotation, panel_width, panel_height
//
// Throughput is bounded by the single-port frame store doing one read and one
// write per pixel. After reset a clearing sweep zeroes all FB_DEPTH words
// of the frame store (131072 by default) with req_ready low; CSR writes
// are taken throughout. A stalled rsp_chan holds its result; up to three
// more pixels are taken into the address pipeline and RMW stage before
// req_ready drops.
module rgb565_alpha_blend_rotated_writer #(
   parameter int unsigned FB_DEPTH = rab_pkg::FB_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   rab_req_if.sink                        req_chan,
   rab_rsp_if.source                      rsp_chan,
   input  logic                           csr_we,
   input  logic [rab_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rab_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import rab_pkg::*;

   localparam int unsigned AW = $clog2(FB_DEPTH);

   rot_type          rotation_ff;
   logic [DIM_W-1:0] panel_width_ff, panel_height_ff;
   cfg_type          cfg;
   logic             pix_valid, pix_ready, fill_busy;
   pix_type          pix;
   logic             ram_we, ram_re;
   logic [AW-1:0]    ram_addr;
   logic [COLOR_W-1:0] ram_wdata, ram_rdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         rotation_ff     <= ROT_0;
         panel_width_ff  <= PANEL_WIDTH_RST;
         panel_height_ff <= PANEL_HEIGHT_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ROTATION:     rotation_ff     <= rot_type'(csr_wdata[1:0]);
            CSR_PANEL_WIDTH:  panel_width_ff  <= csr_wdata;
            CSR_PANEL_HEIGHT: panel_height_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Saturate oversized panels before rotation and bounds
   always_comb begin
      cfg.rotation     = rotation_ff;
      cfg.panel_width  = (panel_width_ff > DIM_W'(MAX_RES)) ? DIM_W'(MAX_RES)
                                                            : panel_width_ff;
      cfg.panel_height = (panel_height_ff > DIM_W'(MAX_RES)) ? DIM_W'(MAX_RES)
                                                             : panel_height_ff;
   end

   rab_map u_map (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .fill_busy (fill_busy),
      .req_chan  (req_chan),
      .pix_valid (pix_valid),
      .pix_ready (pix_ready),
      .pix       (pix)
   );

   rab_rmw #(
      .FB_DEPTH (FB_DEPTH),
      .AW       (AW)
   ) u_rmw (
      .clock     (clock),
      .reset     (reset),
      .pix_valid (pix_valid),
      .pix_ready (pix_ready),
      .pix       (pix),
      .fill_busy (fill_busy),
      .ram_we    (ram_we),
      .ram_re    (ram_re),
      .ram_addr  (ram_addr),
      .ram_wdata (ram_wdata),
      .ram_rdata (ram_rdata),
      .rsp_chan  (rsp_chan)
   );

   rab_fb_ram #(
      .DEPTH (FB_DEPTH),
      .AW    (AW)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .re    (ram_re),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   a_no_req_while_clearing: assert property (@(posedge clock) disable iff (reset)
      fill_busy |-> !req_chan.ready)
      else $error("request taken during frame store clear");

   a_port_single_access: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> !ram_re)
      else $error("frame store read and written in one cycle");

   a_read_then_write: assert property (@(posedge clock) disable iff (reset)
      (ram_re && !fill_busy) |=> !ram_re)
      else $error("frame store read issued twice in a row");

   a_box_ordered: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.data.box_valid) |->
         (rsp_chan.data.box_left < rsp_chan.data.box_right_end &&
          rsp_chan.data.box_top < rsp_chan.data.box_bottom_end))
      else $error("dirty box reported with empty extent");

endmodule

// ===== hw/rtl/rab_fb_ram.sv =====
`timescale 1ns / 1ps
// Single-port framebuffer RAM, one access per cycle, registered read data.
// Depends on rab_pkg for the pixel width.
module rab_fb_ram #(
   parameter int unsigned DEPTH = rab_pkg::FB_DEPTH_DEF,
   parameter int unsigned AW    = $clog2(DEPTH)
) (
   input  logic                        clock,
   input  logic                        we,
   input  logic                        re,
   input  logic [AW-1:0]               addr,
   input  logic [rab_pkg::COLOR_W-1:0] wdata,
   output logic [rab_pkg::COLOR_W-1:0] rdata
);
   import rab_pkg::*;

   logic [COLOR_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end else if (re) begin
         rdata <= mem[addr];
      end
   end

endmodule

// ===== hw/rtl/rab_map.sv =====
`timescale 1ns / 1ps
// Address pipeline: rotation and bounds test, then row * width + column.
// Depends on rab_pkg and the request interface in rab_if.
module rab_map (
   input  logic             clock,
   input  logic             reset,
   input  rab_pkg::cfg_type cfg,
   input  logic             fill_busy,
   rab_req_if.sink          req_chan,
   output logic             pix_valid,
   input  logic             pix_ready,
   output rab_pkg::pix_type pix
);
   import rab_pkg::*;

   logic              s1_valid_ff, s1_valid_in;
   logic              s2_valid_ff, s2_valid_in;
   pix_type           s1_ff, s1_in;
   pix_type           s2_ff, s2_in;
   logic              s1_ready, s2_ready, req_acc;
   logic signed [CALC_W-1:0] sx, sy, lw, lh, dx, dy, pw_s, ph_s;
   logic              in_bounds;

   assign s2_ready       = !s2_valid_ff || pix_ready;
   assign s1_ready       = !s1_valid_ff || s2_ready;
   assign req_chan.ready = s1_ready && !fill_busy;
   assign req_acc        = req_chan.valid && req_chan.ready;

   always_comb begin
      sx   = CALC_W'(req_chan.data.pixel_x);
      sy   = CALC_W'(req_chan.data.pixel_y);
      pw_s = $signed(CALC_W'(cfg.panel_width));
      ph_s = $signed(CALC_W'(cfg.panel_height));
      lw   = cfg.rotation[0] ? ph_s : pw_s;
      lh   = cfg.rotation[0] ? pw_s : ph_s;
      unique case (cfg.rotation)
         ROT_0: begin
            dx = sx;
            dy = sy;
         end
         ROT_90: begin
            dx = lh - CALC_W'(1) - sy;
            dy = sx;
         end
         ROT_180: begin
            dx = lw - CALC_W'(1) - sx;
            dy = lh - CALC_W'(1) - sy;
         end
         ROT_270: begin
            dx = sy;
            dy = lw - CALC_W'(1) - sx;
         end
      endcase
      in_bounds = !dx[CALC_W-1] && !dy[CALC_W-1] && (dx < pw_s) && (dy < ph_s);

      s1_in.keep        = in_bounds &&
                          !(req_chan.data.use_alpha && req_chan.data.alpha_value == ALPHA_SKIP);
      s1_in.blend       = req_chan.data.use_alpha &&
                          (req_chan.data.alpha_value != ALPHA_OPAQUE);
      s1_in.last_pixel  = req_chan.data.last_pixel;
      s1_in.col         = dx[DIM_W-1:0];
      s1_in.row         = dy[DIM_W-1:0];
      s1_in.color       = req_chan.data.color;
      s1_in.alpha_value = req_chan.data.alpha_value;
      s1_in.addr        = '0;

      s2_in      = s1_ff;
      s2_in.addr = PROD_W'(s1_ff.row) * PROD_W'(cfg.panel_width) + PROD_W'(s1_ff.col);

      s1_valid_in = (s1_valid_ff && !s2_ready) || req_acc;
      s2_valid_in = (s2_valid_ff && !pix_ready) || (s1_valid_ff && s2_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_ff <= s1_in;
      end
      if (s1_valid_ff && s2_ready) begin
         s2_ff <= s2_in;
      end
   end

   assign pix_valid = s2_valid_ff;
   assign pix       = s2_ff;

endmodule

// ===== hw/rtl/rab_rmw.sv =====
`timescale 1ns / 1ps
// Read-modify-write engine: clearing sweep, blend, dirty box, result register.
// Depends on rab_pkg, the response interface in rab_if and an external rab_fb_ram.
module rab_rmw #(
   parameter int unsigned FB_DEPTH = rab_pkg::FB_DEPTH_DEF,
   parameter int unsigned AW       = $clog2(FB_DEPTH)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        pix_valid,
   output logic                        pix_ready,
   input  rab_pkg::pix_type            pix,
   output logic                        fill_busy,
   output logic                        ram_we,
   output logic                        ram_re,
   output logic [AW-1:0]               ram_addr,
   output logic [rab_pkg::COLOR_W-1:0] ram_wdata,
   input  logic [rab_pkg::COLOR_W-1:0] ram_rdata,
   rab_rsp_if.source                   rsp_chan
);
   import rab_pkg::*;

   function automatic logic [7:0] blend_ch(input logic [7:0] s, input logic [7:0] o,
                                           input logic [ALPHA_W-1:0] a);
      logic [15:0] acc;
      acc = 16'(s) * 16'(a) + 16'(o) * 16'(ALPHA_OPAQUE - a) + BLEND_ROUND;
      return acc[15:8];
   endfunction

   function automatic logic [COLOR_W-1:0] blend565(input logic [COLOR_W-1:0] src,
                                                   input logic [COLOR_W-1:0] old,
                                                   input logic [ALPHA_W-1:0] a);
      logic [7:0] r, g, b;
      r = blend_ch({src[15:11], 3'b000}, {old[15:11], 3'b000}, a);
      g = blend_ch({src[10:5], 2'b00}, {old[10:5], 2'b00}, a);
      b = blend_ch({src[4:0], 3'b000}, {old[4:0], 3'b000}, a);
      return {r[7:3], g[7:2], b[7:3]};
   endfunction

   rmw_state_type     state_ff, state_in;
   logic [AW-1:0]     clr_ff, clr_in;
   pix_type           cur_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_payload_type   rsp_ff, rsp_in;
   logic              box_seen_ff, box_seen_in;
   logic [BOX_W-1:0]  box_min_col_ff, box_min_row_ff, box_max_col_ff, box_max_row_ff;
   logic [BOX_W-1:0]  min_col_upd, min_row_upd, max_col_upd, max_row_upd;
   logic [BOX_W-1:0]  c, r;
   logic              seen_upd;
   logic              out_free, complete, wr, load_cur;
   logic [COLOR_W-1:0] new_color;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign complete = (state_ff == ST_WRITE) && out_free;
   assign wr       = cur_ff.keep && (cur_ff.addr < PROD_W'(FB_DEPTH));
   assign load_cur = pix_valid && pix_ready;
   assign fill_busy = (state_ff == ST_CLEAR);
   assign new_color = cur_ff.blend ? blend565(cur_ff.color, ram_rdata, cur_ff.alpha_value)
                                   : cur_ff.color;

   // Sequencer: read phase, then write phase; accept the next pixel as the write lands
   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      pix_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(FB_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            pix_ready = 1'b1;
            if (pix_valid) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            pix_ready = out_free;
            if (out_free) begin
               state_in = pix_valid ? ST_READ : ST_IDLE;
            end
         end
      endcase
   end

   always_comb begin
      ram_we    = fill_busy || (complete && wr);
      ram_re    = (state_ff == ST_READ);
      ram_addr  = fill_busy ? clr_ff : cur_ff.addr[AW-1:0];
      ram_wdata = fill_busy ? '0 : new_color;
   end

   // Fold this write into the box before it is reported
   always_comb begin
      c           = cur_ff.col[BOX_W-1:0];
      r           = cur_ff.row[BOX_W-1:0];
      seen_upd    = box_seen_ff || wr;
      min_col_upd = box_min_col_ff;
      min_row_upd = box_min_row_ff;
      max_col_upd = box_max_col_ff;
      max_row_upd = box_max_row_ff;
      if (wr) begin
         if (!box_seen_ff || c < box_min_col_ff) min_col_upd = c;
         if (!box_seen_ff || c > box_max_col_ff) max_col_upd = c;
         if (!box_seen_ff || r < box_min_row_ff) min_row_upd = r;
         if (!box_seen_ff || r > box_max_row_ff) max_row_upd = r;
      end
      box_seen_in = cur_ff.last_pixel ? 1'b0 : seen_upd;

      rsp_in.written        = wr;
      rsp_in.fb_address     = wr ? cur_ff.addr[ADDR_OUT_W-1:0] : '0;
      rsp_in.written_color  = wr ? new_color : '0;
      rsp_in.box_valid      = 1'b0;
      rsp_in.box_left       = '0;
      rsp_in.box_top        = '0;
      rsp_in.box_right_end  = '0;
      rsp_in.box_bottom_end = '0;
      if (cur_ff.last_pixel && seen_upd) begin
         rsp_in.box_valid      = 1'b1;
         rsp_in.box_left       = DIM_W'(min_col_upd);
         rsp_in.box_top        = DIM_W'(min_row_upd);
         rsp_in.box_right_end  = DIM_W'(max_col_upd) + DIM_W'(1);
         rsp_in.box_bottom_end = DIM_W'(max_row_upd) + DIM_W'(1);
      end

      rsp_valid_in = complete || (rsp_valid_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         box_seen_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (complete) begin
            box_seen_ff <= box_seen_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_cur) begin
         cur_ff <= pix;
      end
      if (complete) begin
         rsp_ff         <= rsp_in;
         box_min_col_ff <= min_col_upd;
         box_min_row_ff <= min_row_upd;
         box_max_col_ff <= max_col_upd;
         box_max_row_ff <= max_row_upd;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_ff;

endmodule
